>>> rtl/core/sb2da_pkg.sv
// Shared types, constants and helper functions for the signed binary to
// decimal ASCII converter. No dependencies.
package sb2da_pkg;

   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned DIGITS        = 10;
   localparam int unsigned NARROW_DIGITS = 5;
   localparam int unsigned STAGE_STEPS   = 8;   // dabble steps per pipeline stage
   localparam int unsigned DABBLE_STAGES = VALUE_W / STAGE_STEPS;
   localparam int unsigned POS_W         = 4;   // digit index, 0..9

   localparam logic [7:0]       CHAR_MINUS = 8'd45;
   localparam logic [7:0]       CHAR_ZERO  = 8'd48;
   localparam logic [7:0]       CHAR_NINE  = 8'd57;
   localparam logic [POS_W-1:0] POS_WIDE   = POS_W'(DIGITS - 1);
   localparam logic [POS_W-1:0] POS_NARROW = POS_W'(NARROW_DIGITS - 1);

   typedef logic [DIGITS-1:0][3:0] bcd_type;

   // One number on its way through the conversion pipeline
   typedef struct packed {
      logic                neg;
      logic                wide;
      logic [VALUE_W-1:0]  mag;   // bits not yet shifted into bcd, MSB first
      bcd_type             bcd;
   } word_type;

   // One shift-and-add-3 step: correct every digit, then shift in one bit
   function automatic bcd_type dabble_step(input bcd_type bcd, input logic bit_in);
      bcd_type               fixed;
      logic [DIGITS*4-1:0]   flat;
      fixed = bcd;
      for (int i = 0; i < int'(DIGITS); i++) begin
         if (fixed[i] >= 4'd5) begin
            fixed[i] = fixed[i] + 4'd3;
         end
      end
      flat = fixed;
      return bcd_type'({flat[DIGITS*4-2:0], bit_in});
   endfunction

   function automatic logic bcd_valid(input bcd_type bcd);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < int'(DIGITS); i++) begin
         if (bcd[i] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

>>> rtl/core/signed_binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
// Depends on sb2da_pkg, sb2da_front, sb2da_dabble and sb2da_serial.
//
//   channel | ports              | direction | carries
//   --------+--------------------+-----------+------------------------------
//   req     | req_valid/ready    | in        | req_value, signed 32 bit
//   rsp     | rsp_valid/ready    | out       | rsp_ascii_char, rsp_last_char
//   csr     | csr_valid/ready    | in        | csr_wide_mode, reset value 1
//
// A number gives 10 or 11 characters in wide mode, 5 or 6 in narrow mode,
// one per cycle while rsp is not stalled; that single output port sets the sustained rate.
// From request to first character, the request lands in
// the sign/magnitude stage, then four double-dabble stages of 8 bits each,
// the emitter load and the character register.
// The next number is loaded into the emitter in the cycle its predecessor's
// last digit is written to the character register, so characters flow without gaps under no stall.
// Reset is synchronous, active high: clears all valid bits, sets wide mode.
// A stall on rsp holds the output register; upstream stages fill and then
// hold, losing and repeating nothing.
module signed_binary_to_decimal_ascii (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sb2da_pkg::VALUE_W-1:0]  req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_ascii_char,
   output logic                                  rsp_last_char,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_wide_mode
);
   import sb2da_pkg::*;

   logic      wide_mode_ff;

   // pipeline chain: index 0 is the front stage output
   logic      stg_valid [DABBLE_STAGES+1];
   logic      stg_ready [DABBLE_STAGES+1];
   word_type  stg_word  [DABBLE_STAGES+1];

   // configuration transactions are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff <= 1'b1;
      end else if (csr_valid) begin
         wide_mode_ff <= csr_wide_mode;
      end
   end

   sb2da_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_value  (req_value),
      .wide_mode (wide_mode_ff),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_word  (stg_word[0])
   );

   for (genvar g = 0; g < int'(DABBLE_STAGES); g++) begin : g_dabble
      sb2da_dabble u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_ready  (stg_ready[g]),
         .in_word   (stg_word[g]),
         .out_valid (stg_valid[g+1]),
         .out_ready (stg_ready[g+1]),
         .out_word  (stg_word[g+1])
      );
   end

   sb2da_serial u_serial (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stg_valid[DABBLE_STAGES]),
      .in_ready       (stg_ready[DABBLE_STAGES]),
      .in_word        (stg_word[DABBLE_STAGES]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

>>> rtl/core/sb2da_front.sv
// Input stage: sign detection and magnitude for the selected width.
// Depends on sb2da_pkg.
module sb2da_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [sb2da_pkg::VALUE_W-1:0]  in_value,
   input  logic                                  wide_mode,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output sb2da_pkg::word_type                   out_word
);
   import sb2da_pkg::*;

   logic                valid_ff;
   word_type            word_ff;
   word_type            word_in;
   logic [VALUE_W-1:0]  raw;
   logic [15:0]         raw16;
   logic                neg;

   assign raw   = VALUE_W'(in_value);
   assign raw16 = raw[15:0];

   always_comb begin
      neg = wide_mode ? raw[VALUE_W-1] : raw16[15];
      word_in.neg  = neg;
      word_in.wide = wide_mode;
      word_in.bcd  = '0;
      if (wide_mode) begin
         word_in.mag = neg ? (VALUE_W'(0) - raw) : raw;
      end else begin
         // narrow magnitude reaches 32768 at most, so 16 bits hold it
         word_in.mag = neg ? (VALUE_W'(32'h0001_0000) - {16'd0, raw16}) : {16'd0, raw16};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> rtl/core/sb2da_dabble.sv
// One pipeline stage of the binary to BCD conversion (STAGE_STEPS bits).
// Depends on sb2da_pkg.
module sb2da_dabble (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sb2da_pkg::word_type  in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sb2da_pkg::word_type  out_word
);
   import sb2da_pkg::*;

   logic      valid_ff;
   word_type  word_ff;
   word_type  word_in;

   always_comb begin
      word_in = in_word;
      for (int s = 0; s < int'(STAGE_STEPS); s++) begin
         word_in.bcd = dabble_step(word_in.bcd, word_in.mag[VALUE_W-1]);
         word_in.mag = {word_in.mag[VALUE_W-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // digits stay decimal after every stage
   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> bcd_valid(word_ff.bcd))
      else $error("dabble stage holds a non-decimal digit");

endmodule

>>> rtl/core/sb2da_serial.sv
// Character emitter: minus sign for a negative number, then digits most significant first,
// into a registered output. Depends on sb2da_pkg.
module sb2da_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sb2da_pkg::word_type  in_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_ascii_char,
   output logic                 rsp_last_char
);
   import sb2da_pkg::*;

   logic              busy_ff,  busy_in;
   logic              minus_ff, minus_in;
   logic [POS_W-1:0]  pos_ff,   pos_in;
   bcd_type           bcd_ff;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;
   logic              out_free;
   logic              finishing;
   logic              load;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign finishing = busy_ff && out_free && !minus_ff && (pos_ff == '0);
   assign in_ready  = !busy_ff || finishing;
   assign load      = in_valid && in_ready;

   always_comb begin
      busy_in      = busy_ff;
      minus_in     = minus_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;
      if (busy_ff && out_free) begin
         out_valid_in = 1'b1;
         if (minus_ff) begin
            char_in  = CHAR_MINUS;
            last_in  = 1'b0;
            minus_in = 1'b0;
         end else begin
            char_in = CHAR_ZERO + {4'd0, bcd_ff[pos_ff]};
            last_in = (pos_ff == '0);
            if (pos_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               pos_in = pos_ff - POS_W'(1);
            end
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         minus_in = in_word.neg;
         pos_in   = in_word.wide ? POS_WIDE : POS_NARROW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         minus_ff     <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         minus_ff     <= minus_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (load) begin
         bcd_ff <= in_word.bcd;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= POS_WIDE))
      else $error("digit index out of range");

   a_char_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((char_ff == CHAR_MINUS) ||
                        ((char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE))))
      else $error("output character is neither minus nor digit");

   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ready && (char_ff == CHAR_MINUS)) |=>
         (out_valid_ff && (char_ff != CHAR_MINUS) && !last_ff))
      else $error("minus sign not followed by a leading digit");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for signed_binary_to_decimal_ascii: predicts the decimal text of
// every accepted number and checks each character transaction against it, in both modes.
// Depends on sb2da_pkg and the RTL of the converter; nothing else.

typedef struct packed {
   logic [7:0] ascii_char;
   logic       last_char;
} text_char_type;

// Holds the expected character stream and checks the converter output against it
class decimal_text_scoreboard;
   logic           wide = 1'b1;   // mirror of the mode register, reset value set
   text_char_type  text_q[$];
   int unsigned    mismatches = 0;
   int unsigned    numbers = 0;
   int unsigned    chars = 0;

   task report_mismatch(input string what);
      if (mismatches < 100) begin
         $display("MISMATCH @%0t: %s", $time, what);
      end
      mismatches++;
   endtask

   // Sign, then fixed-width digits with leading zeros; the final digit carries last
   function void note_number(input logic [31:0] value);
      logic           neg;
      logic [31:0]    mag;
      int             ndig;
      logic [7:0]     digit_chars[sb2da_pkg::DIGITS];
      text_char_type  c;
      if (wide) begin
         neg  = value[31];
         mag  = neg ? 32'd0 - value : value;   // unsigned: most negative stays correct
         ndig = int'(sb2da_pkg::DIGITS);
      end else begin
         // narrow: low half only, read as signed 16 bit
         neg  = value[15];
         mag  = neg ? 32'h0001_0000 - {16'h0, value[15:0]} : {16'h0, value[15:0]};
         ndig = int'(sb2da_pkg::NARROW_DIGITS);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
         digit_chars[i] = sb2da_pkg::CHAR_ZERO + 8'(mag % 10);
         mag = mag / 10;
      end
      if (neg) begin
         c.ascii_char = sb2da_pkg::CHAR_MINUS;
         c.last_char  = 1'b0;
         text_q.push_back(c);
      end
      for (int i = 0; i < ndig; i++) begin
         c.ascii_char = digit_chars[i];
         c.last_char  = (i == ndig - 1);
         text_q.push_back(c);
      end
      numbers++;
   endfunction

   task check_char(input logic [7:0] ch, input logic last);
      text_char_type want;
      chars++;
      if (text_q.size() == 0) begin
         report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, last));
         return;
      end
      want = text_q.pop_front();
      if (ch !== want.ascii_char) begin
         report_mismatch($sformatf("ascii_char 0x%02h, want 0x%02h", ch, want.ascii_char));
      end
      if (last !== want.last_char) begin
         report_mismatch($sformatf("last_char %0b, want %0b (char 0x%02h)",
                                   last, want.last_char, want.ascii_char));
      end
   endtask
endclass

module tb_top;

   localparam int unsigned TIMEOUT_CYCLES = 500000;
   localparam int unsigned SETTLE_CYCLES  = 12;   // beyond the pipeline latency

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_ascii_char;
   logic        rsp_last_char;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_wide_mode;

   int unsigned send_idle_pct;    // chance per cycle that the sender holds off
   int unsigned recv_stall_pct;   // chance per cycle that rsp_ready is low
   int unsigned cycles = 0;
   int unsigned wide_writes = 0;
   int unsigned narrow_writes = 0;

   decimal_text_scoreboard sb;

   signed_binary_to_decimal_ascii u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wide_mode  (csr_wide_mode)
   );

   // 12-unit period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost character ends here
   always @(posedge clock) begin
      cycles++;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycles, sb.text_q.size());
         $display("signed_binary_to_decimal_ascii regression: fail");
         $finish;
      end
   end

   // Receiver back-pressure, redrawn every cycle on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Every accepted character transaction goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         sb.check_char(rsp_ascii_char, rsp_last_char);
      end
   end

   // Called and returns at a falling edge. req_valid is left high after the
   // transaction so the next number can follow in the very next cycle; the
   // idle loop lowers it when the sender decides to hold off.
   task automatic send_number(input logic [31:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_number(value);
      @(negedge clock);
   endtask

   // Sender holds until every predicted character has come out
   task automatic drain_text();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.text_q.size() != 0) @(negedge clock);
   endtask

   // Mode changes only with the converter empty and the pipeline settled
   task automatic write_mode(input logic mode);
      drain_text();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_wide_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.wide = mode;
      if (mode) wide_writes++;
      else narrow_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mix of fully random numbers and values near the digit and sign boundaries
   function automatic logic [31:0] random_number();
      logic [31:0] v;
      logic [31:0] p;
      p = 32'd1;
      case ($urandom_range(0, 5))
         0: begin
            v = $urandom_range(0, 99);
         end
         1: begin
            // near the 32-bit extremes
            v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                     : 32'h7FFF_FFFF - $urandom_range(0, 3);
         end
         2: begin
            // near the 16-bit extremes, random upper half
            v[31:16] = 16'($urandom);
            v[15:0]  = $urandom_range(0, 1) ? 16'h8000 + 16'($urandom_range(0, 3))
                                            : 16'h7FFF - 16'($urandom_range(0, 3));
         end
         3: begin
            // a power of ten, or one off it
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = p + $urandom_range(0, 2) - 1;
         end
         default: begin
            v = $urandom;
         end
      endcase
      if ($urandom_range(0, 3) == 0) v = 32'd0 - v;
      return v;
   endfunction

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = 32'd0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_wide_mode = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 30;
      sb = new();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, wide mode straight out of reset: sign, extremes, digit boundaries
      send_number(32'd0);
      send_number(32'd1);
      send_number(32'hFFFF_FFFF);
      send_number(32'h7FFF_FFFF);
      send_number(32'h8000_0000);   // most negative, magnitude does not fit signed
      send_number(32'h8000_0001);
      send_number(32'd9);
      send_number(32'd10);
      send_number(32'd999999999);
      send_number(32'd1000000000);
      send_number(32'd0 - 32'd1000000000);
      send_number(32'd1234567890);
      send_number(32'hAAAA_AAAA);

      // Directed, narrow mode: 16-bit extremes, upper half must be ignored
      write_mode(1'b0);
      send_number(32'd0);
      send_number(32'h0000_7FFF);
      send_number(32'h0000_8000);   // most negative 16-bit value
      send_number(32'h0000_FFFF);
      send_number(32'hFFFF_8000);
      send_number(32'h1234_8000);
      send_number(32'hABCD_7FFF);
      send_number(32'd9999);
      send_number(32'd10000);
      send_number(32'h5555_0001);
      send_number(32'hFFFF_FFFE);

      // Random part: three idling profiles, each with both modes
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct  = 23;
               recv_stall_pct = 83;
            end
            1: begin
               send_idle_pct  = 83;
               recv_stall_pct = 23;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int chunk = 0; chunk < 4; chunk++) begin
            write_mode(chunk[0] ^ ph[0]);
            for (int n = 0; n < 24; n++) begin
               if (ph == 0 && chunk == 1 && n == 12) drain_text();
               send_number(random_number());
            end
         end
      end

      drain_text();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);

      $display("converted %0d numbers into %0d characters over %0d cycles",
               sb.numbers, sb.chars, cycles);
      $display("mode writes: %0d wide, %0d narrow; mismatches: %0d",
               wide_writes, narrow_writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.text_q.size() == 0) begin
         $display("signed_binary_to_decimal_ascii regression: pass");
      end else begin
         $display("signed_binary_to_decimal_ascii regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sb2da_pkg.sv
rtl/core/sb2da_front.sv
rtl/core/sb2da_dabble.sv
rtl/core/sb2da_serial.sv
rtl/core/signed_binary_to_decimal_ascii.sv
dv/tb_top.sv
